// File: hw/rtl/utf8d_pkg.sv
// Shared types, widths and helpers for the UTF-8 stream decoder.
// No dependencies; imported by utf8d_core, utf8d_out_stage and the top level.
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned AccW  = 31;
  localparam int unsigned LenW  = 3;

  // Sequence lengths by lead byte class
  localparam logic [LenW-1:0] LenNone = 3'd0;
  localparam logic [LenW-1:0] Len2    = 3'd2;
  localparam logic [LenW-1:0] Len3    = 3'd3;
  localparam logic [LenW-1:0] Len4    = 3'd4;
  localparam logic [LenW-1:0] Len5    = 3'd5;
  localparam logic [LenW-1:0] Len6    = 3'd6;

  // One result item
  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             unit_valid;
    logic             end_of_string;
  } res_t;

  // Smallest legal value for a sequence of the given length (overlong check)
  function automatic logic [AccW-1:0] min_value(input logic [LenW-1:0] len);
    logic [AccW-1:0] m;
    m = '0;
    unique case (len)
      Len2:    m = AccW'(32'h0000_0080);
      Len3:    m = AccW'(32'h0000_0800);
      Len4:    m = AccW'(32'h0001_0000);
      Len5:    m = AccW'(32'h0020_0000);
      Len6:    m = AccW'(32'h0400_0000);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/utf8d_core.sv
// Per-byte decode logic and sequence state (remaining count, length, accumulator).
// Depends on utf8d_pkg.
module utf8d_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [utf8d_pkg::ByteW-1:0] byte_i,
  input  logic                      last_i,
  output logic                      res_en_o,
  output utf8d_pkg::res_t           res_o
);
  import utf8d_pkg::*;

  logic [LenW-1:0]  rem_q, rem_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic             ended_q, ended_d;

  logic [AccW-1:0]  acc_shift;
  logic [LenW-1:0]  lead_len;
  logic [AccW-1:0]  lead_acc;
  logic [UnitW-1:0] unit;
  logic             vld;

  assign acc_shift = {acc_q[AccW-7:0], byte_i[5:0]};

  // Lead byte class: length and payload bits
  always_comb begin
    lead_len = LenNone;
    lead_acc = '0;
    if (byte_i < 8'hE0) begin
      lead_len = Len2;
      lead_acc = AccW'(byte_i[4:0]);
    end else if (byte_i < 8'hF0) begin
      lead_len = Len3;
      lead_acc = AccW'(byte_i[3:0]);
    end else if (byte_i < 8'hF8) begin
      lead_len = Len4;
      lead_acc = AccW'(byte_i[2:0]);
    end else if (byte_i < 8'hFC) begin
      lead_len = Len5;
      lead_acc = AccW'(byte_i[1:0]);
    end else if (byte_i < 8'hFE) begin
      lead_len = Len6;
      lead_acc = AccW'(byte_i[0]);
    end
  end

  // Next state and result for one byte
  always_comb begin
    rem_d    = rem_q;
    len_d    = len_q;
    acc_d    = acc_q;
    ended_d  = ended_q;
    res_en_o = 1'b0;
    res_o    = '0;
    unit     = '0;
    vld      = 1'b0;
    if (step_i) begin
      if (ended_q) begin
        // bytes after a zero byte are skipped up to the marked last one
        if (last_i) ended_d = 1'b0;
      end else if (byte_i == '0) begin
        rem_d    = '0;
        len_d    = '0;
        acc_d    = '0;
        ended_d  = !last_i;
        res_en_o = 1'b1;
        res_o.end_of_string = 1'b1;
      end else begin
        if (byte_i[7:6] == 2'b10) begin
          // continuation; stray ones are dropped
          if (rem_q != '0) begin
            acc_d = acc_shift;
            rem_d = rem_q - 1'b1;
            if (rem_q == LenW'(1)) begin
              vld   = (acc_shift >= min_value(len_q));
              unit  = vld ? acc_shift[UnitW-1:0] : '0;
              rem_d = '0;
              len_d = '0;
              acc_d = '0;
            end
          end
        end else if (!byte_i[7]) begin
          rem_d = '0;
          len_d = '0;
          acc_d = '0;
          vld   = 1'b1;
          unit  = UnitW'(byte_i);
        end else begin
          // new lead; invalid leads leave nothing pending
          len_d = lead_len;
          acc_d = lead_acc;
          rem_d = (lead_len != LenNone) ? lead_len - 1'b1 : '0;
        end
        if (last_i) begin
          rem_d    = '0;
          len_d    = '0;
          acc_d    = '0;
          res_en_o = 1'b1;
          res_o    = '{code_unit: unit, unit_valid: vld, end_of_string: 1'b1};
        end else if (vld) begin
          res_en_o = 1'b1;
          res_o    = '{code_unit: unit, unit_valid: 1'b1, end_of_string: 1'b0};
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      len_q   <= '0;
      acc_q   <= '0;
      ended_q <= 1'b0;
    end else begin
      rem_q   <= rem_d;
      len_q   <= len_d;
      acc_q   <= acc_d;
      ended_q <= ended_d;
    end
  end

`ifndef SYNTH
  a_rem_lt_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0) |-> (rem_q < len_q))
    else $error("remaining count not below sequence length");

  a_ended_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q |-> (rem_q == '0 && len_q == '0))
    else $error("sequence pending after end of string");

  a_res_meaning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_en_o |-> (res_o.unit_valid || res_o.end_of_string))
    else $error("empty result produced");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (rem_q == '0 && len_q == '0 && !ended_q))
    else $error("state not idle after last byte");
`endif

endmodule

// File: hw/rtl/utf8d_out_stage.sv
// Result register with valid/ready handshake toward the receiver.
// Depends on utf8d_pkg.
module utf8d_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  utf8d_pkg::res_t res_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output utf8d_pkg::res_t res_o
);
  import utf8d_pkg::*;

  logic valid_q;
  res_t res_q;

  // Room for a new result when empty or when the held one leaves now
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: hw/rtl/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder, one byte per transfer in, one code unit per transfer out.
// Input channel: in_valid_i / in_ready_o with in_byte_i and last_byte_i.
// Output channel: out_valid_o / out_ready_i with code_unit_o, unit_valid_o and
// end_of_string_o. A byte yields zero or one result: ASCII bytes and completed
// 2..6 byte sequences give a code unit (low 16 bits of the code point);
// overlong, stray and invalid bytes give nothing; a zero byte or the byte
// flagged last gives a result with end_of_string_o set. After a zero byte,
// bytes are skipped until the one flagged last.
// Flow: a byte is held in the input register, is decoded by single pass
// logic and lands in the result register, from which the result leaves when
// out_ready_i is high. One byte is taken every cycle while the receiver keeps
// up; the input register and the result register together hold two items in
// flight.
// Stall: when out_ready_i is low with a result held, the decode step waits,
// the input register fills and in_ready_o drops; nothing is lost.
// Reset: rst_ni (async, active low) empties both registers and returns the
// decoder to idle with no sequence pending.
// Depends on utf8d_pkg, utf8d_core and utf8d_out_stage.
module utf8_stream_decoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [utf8d_pkg::ByteW-1:0]   in_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [utf8d_pkg::UnitW-1:0]   code_unit_o,
  output logic                          unit_valid_o,
  output logic                          end_of_string_o
);
  import utf8d_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             step;
  logic             free;
  logic             res_en;
  res_t             res;
  res_t             res_out;

  // Decode the held byte whenever the result register can take its outcome
  assign step       = in_valid_q && free;
  assign in_ready_o = !in_valid_q || free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  utf8d_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .res_en_o (res_en),
    .res_o    (res)
  );

  utf8d_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_en),
    .res_i       (res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign code_unit_o     = res_out.code_unit;
  assign unit_valid_o    = res_out.unit_valid;
  assign end_of_string_o = res_out.end_of_string;

`ifndef SYNTH
  a_unit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !unit_valid_o) |-> (code_unit_o == '0))
    else $error("code unit nonzero without valid character");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !free) |=> in_valid_q)
    else $error("held byte lost while result stage full");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && in_valid_q) |-> !in_ready_o)
    else $error("input taken with both registers full");
`endif

endmodule
